### rtl/core/ncpe_pkg.sv
package ncpe_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int MAX_DEGREE_DEF = 7;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_ZERO = 1'b1;

	typedef enum logic {
		REG_DEGREE      = 1'b0,
		REG_POINT_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/core/nurbs_curve_point_evaluator.sv
// evaluate items use a 1-bit-per-cycle divider of width DW = 47 + clog2(MAX_POINTS+1)
// one item at a time: busy stays high until the result strobe; a load item is written while idle and leaves busy low
// result is shown for one cycle with result_valid; the receiver cannot stall
// reset clears degree and point_count; the point table holds garbage until loaded
module nurbs_curve_point_evaluator
	import ncpe_pkg::*;
#(
	parameter int MAX_POINTS = ncpe_pkg::MAX_POINTS_DEF,
	parameter int MAX_DEGREE = ncpe_pkg::MAX_DEGREE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [5:0]         index,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [15:0]        weight,
	input  logic [15:0]        param_t,
	output logic               result_valid,
	output logic signed [15:0] curve_x,
	output logic signed [15:0] curve_y,
	output logic               status
);
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PW   = $clog2(MAX_POINTS + 1);
	localparam int DGW  = $clog2(MAX_DEGREE + 1);
	localparam int WIN  = MAX_DEGREE + 1;
	localparam int QW   = $clog2(MAX_DEGREE + 3);
	localparam int KW   = $clog2(MAX_POINTS + MAX_DEGREE + 2);
	localparam int SFW  = 16 + KW;
	localparam int JW   = KW + 1;
	localparam int XW   = SFW + 2;
	localparam int BW   = 32;
	localparam int ABW  = 21;
	localparam int NW   = 54;
	localparam int WNW  = 30;
	localparam int SUMW = 46 + PW;
	localparam int WSW  = 30 + PW;
	localparam int DW   = 47 + PW;
	localparam int DDW  = 31 + PW;
	localparam int MOW  = 33;
	localparam int MPW  = 2 * MOW;

	typedef enum logic [3:0] {
		S_IDLE, S_SCALE, S_INIT, S_BA, S_BB, S_BC, S_BDIV,
		S_AR, S_AW, S_AN, S_AX, S_AY, S_FIN, S_DX, S_DY
	} state_t;

	state_t state_q;

	logic [2:0] degree_q;
	logic [6:0] point_count_q;
	logic       cfg_wr;

	logic [47:0] mem [MAX_POINTS];
	logic [47:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic [DGW-1:0] deg_q;
	logic [PW-1:0]  pc_q;
	logic [QW-1:0]  q_q;
	logic [DGW-1:0] l_q;
	logic [SFW-1:0] s_q;
	logic [BW-1:0]  win_q [WIN];
	logic [NW-1:0]  acc_q;
	logic [WNW-1:0] wn_q;
	logic signed [SUMW-1:0] sx_q;
	logic signed [SUMW-1:0] sy_q;
	logic [WSW-1:0] wsum_q;

	logic signed [MOW-1:0] ma_q;
	logic signed [MOW-1:0] mb_q;
	logic signed [MPW-1:0] mul_p;

	logic [DGW-1:0] deg_c;
	logic [PW-1:0]  pc_c;
	logic [KW-1:0]  knots_c;
	logic [KW-1:0]  span;
	logic [QW-1:0]  order;
	logic signed [JW-1:0] j;
	logic signed [JW-1:0] jq;
	logic signed [JW-1:0] pc_j;
	logic signed [XW-1:0] a_diff;
	logic signed [XW-1:0] b_diff;
	logic [ABW-1:0] a_v;
	logic [ABW-1:0] b_v;
	logic [DGW-1:0] l1;
	logic [BW-1:0]  win_next;
	logic [NW-1:0]  num;
	logic [MPW-1:0] wn_full;
	logic [WNW-1:0] wn;
	logic           j_ok;
	logic           sx_neg;
	logic           sy_neg;
	logic [SUMW-1:0] mag_x;
	logic [SUMW-1:0] mag_y;

	logic           div_go;
	logic [DW-1:0]  div_n;
	logic [DDW-1:0] div_d;
	logic [DW-1:0]  div_q;
	div_stat_t      div_st;
	logic signed [15:0] sat_v;
	logic           cur_neg;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_DEGREE:      prdata = {29'b0, degree_q};
			REG_POINT_COUNT: prdata = {25'b0, point_count_q};
			default:         prdata = '0;
		endcase
	end

	assign deg_c   = (32'(degree_q) > MAX_DEGREE) ? DGW'(MAX_DEGREE) : DGW'(degree_q);
	assign pc_c    = (32'(point_count_q) > MAX_POINTS) ? PW'(MAX_POINTS) : PW'(point_count_q);
	assign knots_c = KW'(pc_c) + KW'(deg_c) + KW'(1);
	assign span    = s_q[SFW-1:16];
	assign order   = QW'(deg_q) + QW'(1);

	assign j      = JW'(span) - JW'(deg_q) + JW'(l_q);
	assign jq     = j + JW'(q_q);
	assign pc_j   = JW'(pc_q);
	assign a_diff = XW'(s_q) - (XW'(j) <<< 16);
	assign b_diff = (XW'(jq) <<< 16) - XW'(s_q);
	assign a_v    = (j < 0 || a_diff < 0) ? '0 : ABW'(a_diff);
	assign b_v    = (j < 0 || b_diff < 0) ? '0 : ABW'(b_diff);
	assign l1     = DGW'(l_q + 1'b1);
	assign win_next = (l_q == deg_q) ? '0 : win_q[l1];
	assign j_ok   = (j >= 0) && (j < pc_j);
	assign rd_addr = AW'(j);

	assign mul_p  = ma_q * mb_q;
	assign num    = acc_q + NW'(mul_p);
	assign wn_full = MPW'(mul_p) + MPW'(1 << 17);
	assign wn     = WNW'(wn_full >> 18);

	assign sx_neg = sx_q[SUMW-1];
	assign sy_neg = sy_q[SUMW-1];
	assign mag_x  = sx_neg ? SUMW'(-sx_q) : SUMW'(sx_q);
	assign mag_y  = sy_neg ? SUMW'(-sy_q) : SUMW'(sy_q);

	always_comb begin
		div_go = 1'b0;
		div_n  = '0;
		div_d  = '0;
		if (state_q == S_BC) begin
			div_go = 1'b1;
			div_n  = DW'((num + (NW'(q_q - 1'b1) << 15)) >> 16);
			div_d  = DDW'(q_q - 1'b1);
		end else if (state_q == S_FIN && wsum_q != '0) begin
			div_go = 1'b1;
			div_n  = DW'({mag_x, 1'b0}) + DW'(wsum_q);
			div_d  = DDW'({wsum_q, 1'b0});
		end else if (state_q == S_DX && div_st.done) begin
			div_go = 1'b1;
			div_n  = DW'({mag_y, 1'b0}) + DW'(wsum_q);
			div_d  = DDW'({wsum_q, 1'b0});
		end
	end

	assign cur_neg = (state_q == S_DX) ? sx_neg : sy_neg;

	always_comb begin
		if (cur_neg) begin
			sat_v = (div_q > DW'(32768)) ? 16'sh8000 : 16'(-div_q);
		end else begin
			sat_v = (div_q > DW'(32767)) ? 16'sh7fff : 16'(div_q);
		end
	end

	ncpe_div #(
		.DW  (DW),
		.DDW (DDW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_n),
		.divisor  (div_d),
		.quot     (div_q),
		.stat     (div_st)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && op == OP_LOAD && 32'(index) < MAX_POINTS) begin
			mem[AW'(index)] <= {point_x, point_y, weight};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			degree_q      <= '0;
			point_count_q <= '0;
			result_valid  <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_wr) begin
				unique case (reg_idx_t'(paddr[2]))
					REG_DEGREE:      degree_q <= pwdata[2:0];
					REG_POINT_COUNT: point_count_q <= pwdata[6:0];
					default:         ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start && op == OP_EVAL) begin
						deg_q   <= deg_c;
						pc_q    <= pc_c;
						ma_q    <= MOW'(param_t);
						mb_q    <= MOW'(knots_c);
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					s_q     <= SFW'(mul_p);
					state_q <= S_INIT;
				end
				S_INIT: begin
					for (int i = 0; i < WIN; i++) begin
						win_q[i] <= (DGW'(i) == deg_q) ? BW'(1 << 30) : '0;
					end
					q_q    <= QW'(2);
					l_q    <= '0;
					sx_q   <= '0;
					sy_q   <= '0;
					wsum_q <= '0;
					state_q <= (deg_q == '0) ? S_AR : S_BA;
				end
				S_BA: begin
					ma_q    <= MOW'(a_v);
					mb_q    <= MOW'(win_q[l_q]);
					state_q <= S_BB;
				end
				S_BB: begin
					acc_q   <= NW'(mul_p);
					ma_q    <= MOW'(b_v);
					mb_q    <= MOW'(win_next);
					state_q <= S_BC;
				end
				S_BC: begin
					state_q <= S_BDIV;
				end
				S_BDIV: begin
					if (div_st.done) begin
						win_q[l_q] <= div_q[BW-1:0];
						if (l_q == deg_q) begin
							l_q <= '0;
							if (q_q == order) begin
								state_q <= S_AR;
							end else begin
								q_q     <= q_q + 1'b1;
								state_q <= S_BA;
							end
						end else begin
							l_q     <= l_q + 1'b1;
							state_q <= S_BA;
						end
					end
				end
				S_AR: begin
					if (j_ok) begin
						state_q <= S_AW;
					end else if (l_q == deg_q) begin
						state_q <= S_FIN;
					end else begin
						l_q <= l_q + 1'b1;
					end
				end
				S_AW: begin
					ma_q    <= MOW'(rd_q[15:0]);
					mb_q    <= MOW'(win_q[l_q]);
					state_q <= S_AN;
				end
				S_AN: begin
					wn_q    <= wn;
					ma_q    <= MOW'(wn);
					mb_q    <= MOW'($signed(rd_q[47:32]));
					state_q <= S_AX;
				end
				S_AX: begin
					sx_q    <= sx_q + SUMW'(mul_p);
					mb_q    <= MOW'($signed(rd_q[31:16]));
					state_q <= S_AY;
				end
				S_AY: begin
					sy_q   <= sy_q + SUMW'(mul_p);
					wsum_q <= wsum_q + WSW'(wn_q);
					if (l_q == deg_q) begin
						state_q <= S_FIN;
					end else begin
						l_q     <= l_q + 1'b1;
						state_q <= S_AR;
					end
				end
				S_FIN: begin
					if (wsum_q == '0) begin
						curve_x      <= '0;
						curve_y      <= '0;
						status       <= ST_ZERO;
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_DX;
					end
				end
				S_DX: begin
					if (div_st.done) begin
						curve_x <= sat_v;
						state_q <= S_DY;
					end
				end
				S_DY: begin
					if (div_st.done) begin
						curve_y      <= sat_v;
						status       <= ST_OK;
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result while still busy");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_ZERO) |-> (curve_x == 0 && curve_y == 0))
		else $error("flagged result with nonzero coordinates");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_BDIV || state_q == S_DX || state_q == S_DY))
		else $error("divider finished outside a wait state");

	a_lane_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BA || state_q == S_AR) |-> (l_q <= deg_q))
		else $error("basis lane beyond degree");

endmodule

### rtl/core/ncpe_div.sv
module ncpe_div #(
	parameter int DW  = 53,
	parameter int DDW = 37
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [DW-1:0]      dividend,
	input  logic [DDW-1:0]     divisor,
	output logic [DW-1:0]      quot,
	output ncpe_pkg::div_stat_t stat
);
	import ncpe_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DDW-1:0] rem_q;
	logic [DW-1:0]  quo_q;
	logic [DDW-1:0] d_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DDW:0]   sh;
	logic [DDW:0]   diff;
	logic           ge;

	assign sh   = {rem_q, quo_q[DW-1]};
	assign ge   = sh >= {1'b0, d_q};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
				rem_q  <= '0;
				quo_q  <= dividend;
				d_q    <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DDW-1:0] : sh[DDW-1:0];
				quo_q <= {quo_q[DW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot      = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### tb/ncpe_checker.sv
`timescale 1ns / 100ps

module ncpe_checker
	import ncpe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               start,
	input  logic               busy,
	input  logic               op,
	input  logic [5:0]         index,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [15:0]        weight,
	input  logic [15:0]        param_t,
	input  logic               result_valid,
	input  logic signed [15:0] curve_x,
	input  logic signed [15:0] curve_y,
	input  logic               status,
	output int                 fail_count,
	output int                 pending_count,
	output int                 points_checked
);

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               st;
	} curve_point_t;

	localparam int BASIS_LEN = MAX_POINTS_DEF + MAX_DEGREE_DEF + 1;

	logic [15:0]  px_tab [MAX_POINTS_DEF];
	logic [15:0]  py_tab [MAX_POINTS_DEF];
	logic [15:0]  w_tab  [MAX_POINTS_DEF];
	logic [2:0]   cfg_degree;
	logic [6:0]   cfg_count;
	curve_point_t curve_q[$];

	function automatic logic signed [15:0] round_div(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned qv;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		qv = (2 * mag + den) / (2 * den);
		if (num < 0)
			return (qv > 32768) ? -16'sd32768 : 16'(-longint'(qv));
		return (qv > 32767) ? 16'sd32767 : 16'(qv);
	endfunction

	function automatic curve_point_t eval_point(logic [15:0] t);
		longint unsigned basis [BASIS_LEN];
		int unsigned     pc, deg, knots, span;
		longint unsigned s, den, lo, hi, a, b, num, wn, wsum;
		longint          sx, sy;
		curve_point_t    r;
		pc = (cfg_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cfg_count;
		deg = (cfg_degree > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : cfg_degree;
		knots = pc + deg + 1;
		s = longint'(t) * knots;
		span = 32'(s >> 16);
		sx = 0;
		sy = 0;
		wsum = 0;
		for (int j = 0; j < knots; j++)
			basis[j] = (j == span) ? (64'd1 << 30) : 64'd0;
		for (int q = 2; q <= deg + 1; q++) begin
			den = longint'(q - 1) << 16;
			for (int j = 0; j + q <= knots; j++) begin
				lo = longint'(j) << 16;
				hi = longint'(j + q) << 16;
				a = (s > lo) ? s - lo : 0;
				b = (hi > s) ? hi - s : 0;
				num = a * basis[j] + b * basis[j + 1];
				basis[j] = (num + den / 2) / den;
			end
		end
		for (int k = 0; k < pc; k++) begin
			wn = (longint'(w_tab[k]) * basis[k] + (64'd1 << 17)) >> 18;
			sx += longint'(wn) * longint'($signed(px_tab[k]));
			sy += longint'(wn) * longint'($signed(py_tab[k]));
			wsum += wn;
		end
		if (wsum == 0) begin
			r.x = '0;
			r.y = '0;
			r.st = ST_ZERO;
		end else begin
			r.x = round_div(sx, wsum);
			r.y = round_div(sy, wsum);
			r.st = ST_OK;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
		points_checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		curve_point_t want;
		if (!arst_n) begin
			cfg_degree <= '0;
			cfg_count <= '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_DEGREE:      cfg_degree <= pwdata[2:0];
					REG_POINT_COUNT: cfg_count <= pwdata[6:0];
				endcase
			end
			if (start && !busy) begin
				if (op == OP_LOAD) begin
					px_tab[index] = point_x;
					py_tab[index] = point_y;
					w_tab[index] = weight;
				end else begin
					curve_q.push_back(eval_point(param_t));
				end
			end
			if (result_valid) begin
				if (curve_q.size() == 0) begin
					report_mismatch("unexpected curve point", 1, 0);
				end else begin
					want = curve_q.pop_front();
					points_checked++;
					if (curve_x !== want.x)
						report_mismatch("curve_x", curve_x, want.x);
					if (curve_y !== want.y)
						report_mismatch("curve_y", curve_y, want.y);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
				end
			end
			pending_count <= curve_q.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ncpe_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic               op = OP_LOAD;
	logic [5:0]         index = '0;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic [15:0]        weight = '0;
	logic [15:0]        param_t = '0;
	logic               result_valid;
	logic signed [15:0] curve_x;
	logic signed [15:0] curve_y;
	logic               status;
	int                 fail_count;
	int                 pending_count;
	int                 points_checked;
	int                 items_sent = 0;
	bit                 idle_on = 1'b1;

	nurbs_curve_point_evaluator u_dut (.*);

	ncpe_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#400_000_000;
		$display("timeout");
		$display("FAIL nurbs_curve_point_evaluator");
		$finish;
	end

	task automatic reg_write(reg_idx_t r, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(r) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(logic o, logic [5:0] idx, logic [15:0] x, logic [15:0] y,
			logic [15:0] w, logic [15:0] t);
		if (idle_on && $urandom_range(0, 99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		index <= idx;
		point_x <= x;
		point_y <= y;
		weight <= w;
		param_t <= t;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic drain;
		start <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (20) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_t();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic load_point(int idx);
		send_item(OP_LOAD, 6'(idx), rand_coord(), rand_coord(), rand_weight(), 16'($urandom));
	endtask

	task automatic eval_at(logic [15:0] t);
		send_item(OP_EVAL, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), t);
	endtask

	initial begin
		int phase_deg [10] = '{0, 1, 2, 3, 7, 7, 5, 0, 4, 2};
		int phase_cnt [10] = '{64, 2, 10, 64, 127, 1, 33, 1, 8, 64};
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no points in use: weight sum is zero
		eval_at(16'h0000);
		eval_at(16'h8000);
		drain();
		for (int i = 0; i < 64; i++)
			send_item(OP_LOAD, 6'(i), (i % 2) ? 16'h8000 : 16'h7fff,
				(i % 2) ? 16'h7fff : 16'h8000, (i == 5) ? 16'h0000 : 16'hffff, '0);
		drain();
		reg_write(REG_DEGREE, 32'd0);
		reg_write(REG_POINT_COUNT, 32'd64);
		eval_at(16'h0000);
		eval_at(16'hffff);
		eval_at(16'h7fff);
		drain();
		// all weights zero, then equal nonzero weights
		reg_write(REG_DEGREE, 32'd2);
		reg_write(REG_POINT_COUNT, 32'd4);
		for (int i = 0; i < 4; i++)
			send_item(OP_LOAD, 6'(i), rand_coord(), rand_coord(), 16'h0000, '0);
		eval_at(16'h4000);
		eval_at(16'hffff);
		for (int i = 0; i < 4; i++)
			send_item(OP_LOAD, 6'(i), 16'h7fff, 16'h8000, 16'h1000, '0);
		eval_at(16'h6000);
		drain();
		reg_write(REG_DEGREE, 32'hffff_ffff);
		reg_write(REG_POINT_COUNT, 32'd127);
		eval_at(16'h0000);
		eval_at(16'hffff);
		eval_at(16'h8123);

		for (int p = 0; p < 10; p++) begin
			drain();
			reg_write(REG_DEGREE, 32'(phase_deg[p]));
			reg_write(REG_POINT_COUNT, 32'(phase_cnt[p]));
			idle_on = (p != 3);
			n = (phase_deg[p] >= 5) ? 70 : 150;
			for (int i = 0; i < n; i++) begin
				if (p == 5 && i == 30)
					drain();
				if ($urandom_range(0, 99) < 40)
					load_point($urandom_range(0, 63));
				else
					eval_at(rand_t());
			end
		end
		drain();

		$display("sent %0d items over 14 register settings, %0d curve points checked",
			items_sent, points_checked);
		if (fail_count == 0 && pending_count == 0)
			$display("PASS nurbs_curve_point_evaluator");
		else
			$display("FAIL nurbs_curve_point_evaluator");
		$finish;
	end

endmodule

### sim.f
rtl/core/ncpe_pkg.sv
rtl/core/ncpe_div.sv
rtl/core/nurbs_curve_point_evaluator.sv
tb/ncpe_checker.sv
tb/tb_top.sv
